// ===== rtl/ppoi_pkg.sv =====
`timescale 1ns / 1ps

package ppoi_pkg;

    // payload widths fixed by the word formats
    localparam int VEL_W     = 16;
    localparam int RATE_W    = 21;
    localparam int DT_W      = 16;
    localparam int LOAD_W    = 32;
    localparam int OUT_POS_W = 32;
    localparam int QUAT_W    = 16;

    // opcodes
    localparam logic OP_INTEGRATE = 1'b0;
    localparam logic OP_LOAD      = 1'b1;

    // cordic, angles as a 32-bit turn fraction, results in q1.30
    localparam int TRIG_W       = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int ROT_IDX_W    = $clog2(CORDIC_STEPS);
    localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 32'sd652032874;

    // shared multiplier and accumulators
    localparam int MUL_A_W     = 32;
    localparam int MUL_B_W     = 18;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int VSUM_W      = 48;
    localparam int SPLIT       = 24;
    localparam int ACC_W       = 64;
    localparam int ROUND_SHIFT = 38;
    localparam int DELTA_W     = ACC_W - ROUND_SHIFT;
    localparam int HEAD_SHIFT  = 16;

    localparam logic signed [QUAT_W:0] Q14_MAX = 17'sd16384;
    localparam logic signed [QUAT_W:0] Q14_MIN = -17'sd16384;

    // position phase steps, one per cycle
    typedef enum logic [3:0] {
        PS_VXC  = 4'd0,
        PS_VYS  = 4'd1,
        PS_VXS  = 4'd2,
        PS_VYC  = 4'd3,
        PS_XLO  = 4'd4,
        PS_XHI  = 4'd5,
        PS_YLO  = 4'd6,
        PS_YHI  = 4'd7,
        PS_YACC = 4'd8,
        PS_YPOS = 4'd9
    } pos_step_t;

    typedef struct packed {
        logic                 capture;
        logic                 load_pose;
        logic                 head_mul;
        logic                 head_add;
        logic                 rot;
        logic [ROT_IDX_W-1:0] rot_idx;
        logic                 map;
        logic                 pos;
        pos_step_t            pos_step;
        logic                 out_load;
    } ppoi_cmd_t;

    // atan(2^-i) as a 32-bit turn fraction
    function automatic logic signed [TRIG_W-1:0] cordic_atan(input logic [ROT_IDX_W-1:0] idx);
        logic signed [TRIG_W-1:0] r;
        case (idx)
            5'd0:    r = 32'sd536870912;
            5'd1:    r = 32'sd316933406;
            5'd2:    r = 32'sd167458907;
            5'd3:    r = 32'sd85004756;
            5'd4:    r = 32'sd42667331;
            5'd5:    r = 32'sd21354465;
            5'd6:    r = 32'sd10679838;
            5'd7:    r = 32'sd5340245;
            5'd8:    r = 32'sd2670163;
            5'd9:    r = 32'sd1335087;
            5'd10:   r = 32'sd667544;
            5'd11:   r = 32'sd333772;
            5'd12:   r = 32'sd166886;
            5'd13:   r = 32'sd83443;
            5'd14:   r = 32'sd41722;
            5'd15:   r = 32'sd20861;
            5'd16:   r = 32'sd10430;
            5'd17:   r = 32'sd5215;
            5'd18:   r = 32'sd2608;
            5'd19:   r = 32'sd1304;
            5'd20:   r = 32'sd652;
            5'd21:   r = 32'sd326;
            5'd22:   r = 32'sd163;
            5'd23:   r = 32'sd81;
            5'd24:   r = 32'sd41;
            5'd25:   r = 32'sd20;
            5'd26:   r = 32'sd10;
            5'd27:   r = 32'sd5;
            5'd28:   r = 32'sd3;
            5'd29:   r = 32'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/ppoi_in_if.sv =====
`timescale 1ns / 1ps

interface ppoi_in_if #(parameter int HEAD_W = 17);
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic signed [ppoi_pkg::VEL_W-1:0]   lin_x;
    logic signed [ppoi_pkg::VEL_W-1:0]   lin_y;
    logic signed [ppoi_pkg::RATE_W-1:0]  ang_rate;
    logic        [ppoi_pkg::DT_W-1:0]    elapsed;
    logic signed [ppoi_pkg::LOAD_W-1:0]  load_x;
    logic signed [ppoi_pkg::LOAD_W-1:0]  load_y;
    logic        [HEAD_W-1:0]            load_heading;

    modport source (
        output valid, opcode, lin_x, lin_y, ang_rate, elapsed, load_x, load_y, load_heading,
        input  ready
    );
    modport sink (
        input  valid, opcode, lin_x, lin_y, ang_rate, elapsed, load_x, load_y, load_heading,
        output ready
    );
endinterface

// ===== rtl/ppoi_out_if.sv =====
`timescale 1ns / 1ps

interface ppoi_out_if #(parameter int HEAD_W = 17);
    logic                                  valid;
    logic                                  ready;
    logic signed [ppoi_pkg::OUT_POS_W-1:0] pos_x;
    logic signed [ppoi_pkg::OUT_POS_W-1:0] pos_y;
    logic        [HEAD_W-1:0]              heading;
    logic signed [ppoi_pkg::QUAT_W-1:0]    quat_z;
    logic signed [ppoi_pkg::QUAT_W-1:0]    quat_w;

    modport source (
        output valid, pos_x, pos_y, heading, quat_z, quat_w,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, heading, quat_z, quat_w,
        output ready
    );
endinterface

// ===== rtl/planar_pose_odometry_integrator.sv =====
`timescale 1ns / 1ps
// velocity word: heading, cordic, map, position; done loads the result, then idle again
// the 30-step cordic loop is the longest phase; both sine/cosine lanes run side by side
// load word: pose set at the accepting edge, no result, next word taken the cycle after
// a finished result waits in the output register; the block stalls only when it is full
// reset (rst_n low, asynchronous) clears the pose to zero and drops any pending result

module planar_pose_odometry_integrator #(
    parameter int POS_WIDTH  = 32,   // internal pose width, 24 to 48
    parameter int ANGLE_BITS = 16    // heading units per turn as a power of two, 12 to 20
) (
    input  logic       clk,
    input  logic       rst_n,
    ppoi_in_if.sink    sample,   // heading fields carry ANGLE_BITS + 1 bits
    ppoi_out_if.source result
);

    ppoi_pkg::ppoi_cmd_t cmd;

    // sequencer: handshakes plus one command word per cycle
    ppoi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .opcode    (sample.opcode),
        .in_ready  (sample.ready),
        .out_ready (result.ready),
        .out_valid (result.valid),
        .cmd       (cmd)
    );

    // datapath: pose, shared multiplier, two cordic lanes, output register
    ppoi_dp #(
        .POS_WIDTH  (POS_WIDTH),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .lin_x        (sample.lin_x),
        .lin_y        (sample.lin_y),
        .ang_rate     (sample.ang_rate),
        .elapsed      (sample.elapsed),
        .load_x       (sample.load_x),
        .load_y       (sample.load_y),
        .load_heading (sample.load_heading),
        .pos_x        (result.pos_x),
        .pos_y        (result.pos_y),
        .heading      (result.heading),
        .quat_z       (result.quat_z),
        .quat_w       (result.quat_w)
    );

endmodule

// ===== rtl/ppoi_ctrl.sv =====
`timescale 1ns / 1ps

module ppoi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                opcode,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    output ppoi_pkg::ppoi_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_HMUL = 7'b0000010,
        S_HADD = 7'b0000100,
        S_ROT  = 7'b0001000,
        S_MAP  = 7'b0010000,
        S_POS  = 7'b0100000,
        S_DONE = 7'b1000000
    } state_t;

    state_t                         state_reg, state_next;
    logic [ppoi_pkg::ROT_IDX_W-1:0] cnt_reg, cnt_next;
    ppoi_pkg::pos_step_t            step_reg, step_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.rot_idx    = cnt_reg;
        cmd.pos_step   = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (opcode == ppoi_pkg::OP_LOAD))
                begin
                    cmd.load_pose = 1'b1;
                end
                else if (accept)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_HMUL;
                end
            end
            S_HMUL:
            begin
                cmd.head_mul = 1'b1;
                state_next   = S_HADD;
            end
            S_HADD:
            begin
                cmd.head_add = 1'b1;
                cnt_next     = '0;
                state_next   = S_ROT;
            end
            S_ROT:
            begin
                cmd.rot = 1'b1;
                if (cnt_reg == ppoi_pkg::ROT_IDX_W'(ppoi_pkg::CORDIC_STEPS - 1))
                begin
                    state_next = S_MAP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_MAP:
            begin
                cmd.map    = 1'b1;
                step_next  = ppoi_pkg::PS_VXC;
                state_next = S_POS;
            end
            S_POS:
            begin
                cmd.pos = 1'b1;
                if (step_reg == ppoi_pkg::PS_YPOS)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = ppoi_pkg::pos_step_t'(4'(step_reg) + 4'd1);
                end
            end
            S_DONE:
            begin
                // wait until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            step_reg      <= ppoi_pkg::PS_VXC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/ppoi_dp.sv =====
`timescale 1ns / 1ps

module ppoi_dp #(
    parameter int POS_WIDTH  = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ppoi_pkg::ppoi_cmd_t                   cmd,
    input  logic signed [ppoi_pkg::VEL_W-1:0]     lin_x,
    input  logic signed [ppoi_pkg::VEL_W-1:0]     lin_y,
    input  logic signed [ppoi_pkg::RATE_W-1:0]    ang_rate,
    input  logic        [ppoi_pkg::DT_W-1:0]      elapsed,
    input  logic signed [ppoi_pkg::LOAD_W-1:0]    load_x,
    input  logic signed [ppoi_pkg::LOAD_W-1:0]    load_y,
    input  logic        [ANGLE_BITS:0]            load_heading,
    output logic signed [ppoi_pkg::OUT_POS_W-1:0] pos_x,
    output logic signed [ppoi_pkg::OUT_POS_W-1:0] pos_y,
    output logic        [ANGLE_BITS:0]            heading,
    output logic signed [ppoi_pkg::QUAT_W-1:0]    quat_z,
    output logic signed [ppoi_pkg::QUAT_W-1:0]    quat_w
);

    localparam int HW    = ANGLE_BITS + 1;
    localparam int TW    = ppoi_pkg::TRIG_W;
    localparam int AW    = ppoi_pkg::MUL_A_W;
    localparam int BW    = ppoi_pkg::MUL_B_W;
    localparam int PW    = ppoi_pkg::PROD_W;
    localparam int VW    = ppoi_pkg::VSUM_W;
    localparam int SP    = ppoi_pkg::SPLIT;
    localparam int CW    = ppoi_pkg::ACC_W;
    localparam int DW    = ppoi_pkg::DELTA_W;
    localparam int SUM_W = ((POS_WIDTH > ppoi_pkg::OUT_POS_W) ? POS_WIDTH
                                                               : ppoi_pkg::OUT_POS_W) + 1;
    localparam logic signed [SUM_W-1:0] POS_MAX =
        {{(SUM_W - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;
    localparam logic signed [CW-1:0] POS_HALF = CW'(1) <<< (ppoi_pkg::ROUND_SHIFT - 1);
    localparam logic signed [PW-1:0] HEAD_HALF = PW'(1) <<< (ppoi_pkg::HEAD_SHIFT - 1);

    // pose
    logic signed [POS_WIDTH-1:0] pose_x_reg, pose_y_reg;
    logic        [HW-1:0]        pose_head_reg;

    // captured sample
    logic signed [ppoi_pkg::VEL_W-1:0]  vx_reg, vy_reg;
    logic signed [ppoi_pkg::RATE_W-1:0] rate_reg;
    logic        [ppoi_pkg::DT_W-1:0]   dt_reg;

    // multiplier and sums
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] product, prod_reg;
    logic signed [CW-1:0] prod_ext;
    logic signed [VW-1:0] vsx_reg, vsy_reg;
    logic signed [CW-1:0] pacc_reg;

    // cordic lanes: lane 0 old heading, lane 1 half of new heading
    logic signed [TW-1:0] cx_reg [2];
    logic signed [TW-1:0] cy_reg [2];
    logic signed [TW-1:0] cz_reg [2];
    logic        [1:0]    quad_reg [2];
    logic signed [TW-1:0] cx_step [2];
    logic signed [TW-1:0] cy_step [2];
    logic signed [TW-1:0] cz_step [2];
    logic        [TW-1:0] angle [2];
    logic signed [TW-1:0] c_map [2];
    logic signed [TW-1:0] s_map [2];
    logic signed [TW-1:0] cos_reg [2];
    logic signed [TW-1:0] sin_reg [2];
    logic signed [TW-1:0] atan_val;

    logic signed [PW-1:0]    head_sum;
    logic        [HW-1:0]    head_new;
    logic signed [CW-1:0]    rnd_sum;
    logic signed [DW-1:0]    delta;
    logic signed [POS_WIDTH-1:0] pos_base;
    logic signed [SUM_W-1:0] pos_sum;
    logic        [POS_WIDTH-1:0] pos_upd;
    logic signed [SUM_W-1:0] pose_x_ext, pose_y_ext;

    function automatic logic [POS_WIDTH-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic [POS_WIDTH-1:0] r;
        if (v > POS_MAX)
            r = POS_MAX[POS_WIDTH-1:0];
        else if (v < POS_MIN)
            r = POS_MIN[POS_WIDTH-1:0];
        else
            r = v[POS_WIDTH-1:0];
        return r;
    endfunction

    function automatic logic signed [ppoi_pkg::QUAT_W-1:0] to_q14(
        input logic signed [TW-1:0] v
    );
        logic signed [TW:0]               t;
        logic signed [ppoi_pkg::QUAT_W:0] q;
        t = {v[TW-1], v} + (TW + 1)'(32768);
        q = t[TW:ppoi_pkg::HEAD_SHIFT];
        if (q > ppoi_pkg::Q14_MAX)
            q = ppoi_pkg::Q14_MAX;
        else if (q < ppoi_pkg::Q14_MIN)
            q = ppoi_pkg::Q14_MIN;
        return q[ppoi_pkg::QUAT_W-1:0];
    endfunction

    // heading step from rate * dt, rounded half up
    assign head_sum = prod_reg + HEAD_HALF;
    assign head_new = pose_head_reg + head_sum[ppoi_pkg::HEAD_SHIFT +: HW];

    assign angle[0] = {pose_head_reg[ANGLE_BITS-1:0], {(TW - ANGLE_BITS){1'b0}}};
    assign angle[1] = {head_new, {(TW - 1 - ANGLE_BITS){1'b0}}};

    assign atan_val = ppoi_pkg::cordic_atan(cmd.rot_idx);

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (!cz_reg[l][TW-1])
            begin
                cx_step[l] = cx_reg[l] - (cy_reg[l] >>> cmd.rot_idx);
                cy_step[l] = cy_reg[l] + (cx_reg[l] >>> cmd.rot_idx);
                cz_step[l] = cz_reg[l] - atan_val;
            end
            else
            begin
                cx_step[l] = cx_reg[l] + (cy_reg[l] >>> cmd.rot_idx);
                cy_step[l] = cy_reg[l] - (cx_reg[l] >>> cmd.rot_idx);
                cz_step[l] = cz_reg[l] + atan_val;
            end
            case (quad_reg[l])
                2'd0:
                begin
                    c_map[l] = cx_reg[l];
                    s_map[l] = cy_reg[l];
                end
                2'd1:
                begin
                    c_map[l] = -cy_reg[l];
                    s_map[l] = cx_reg[l];
                end
                2'd2:
                begin
                    c_map[l] = -cx_reg[l];
                    s_map[l] = -cy_reg[l];
                end
                default:
                begin
                    c_map[l] = cy_reg[l];
                    s_map[l] = -cx_reg[l];
                end
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.head_mul)
        begin
            mul_a = {{(AW - ppoi_pkg::RATE_W){rate_reg[ppoi_pkg::RATE_W-1]}}, rate_reg};
            mul_b = {{(BW - ppoi_pkg::DT_W){1'b0}}, dt_reg};
        end
        else if (cmd.pos)
        begin
            case (cmd.pos_step)
                ppoi_pkg::PS_VXC:
                begin
                    mul_a = cos_reg[0];
                    mul_b = {{(BW - ppoi_pkg::VEL_W){vx_reg[ppoi_pkg::VEL_W-1]}}, vx_reg};
                end
                ppoi_pkg::PS_VYS:
                begin
                    mul_a = sin_reg[0];
                    mul_b = {{(BW - ppoi_pkg::VEL_W){vy_reg[ppoi_pkg::VEL_W-1]}}, vy_reg};
                end
                ppoi_pkg::PS_VXS:
                begin
                    mul_a = sin_reg[0];
                    mul_b = {{(BW - ppoi_pkg::VEL_W){vx_reg[ppoi_pkg::VEL_W-1]}}, vx_reg};
                end
                ppoi_pkg::PS_VYC:
                begin
                    mul_a = cos_reg[0];
                    mul_b = {{(BW - ppoi_pkg::VEL_W){vy_reg[ppoi_pkg::VEL_W-1]}}, vy_reg};
                end
                ppoi_pkg::PS_XLO:
                begin
                    mul_a = {{(AW - SP){1'b0}}, vsx_reg[SP-1:0]};
                    mul_b = {{(BW - ppoi_pkg::DT_W){1'b0}}, dt_reg};
                end
                ppoi_pkg::PS_XHI:
                begin
                    mul_a = {{(AW - (VW - SP)){vsx_reg[VW-1]}}, vsx_reg[VW-1:SP]};
                    mul_b = {{(BW - ppoi_pkg::DT_W){1'b0}}, dt_reg};
                end
                ppoi_pkg::PS_YLO:
                begin
                    mul_a = {{(AW - SP){1'b0}}, vsy_reg[SP-1:0]};
                    mul_b = {{(BW - ppoi_pkg::DT_W){1'b0}}, dt_reg};
                end
                ppoi_pkg::PS_YHI:
                begin
                    mul_a = {{(AW - (VW - SP)){vsy_reg[VW-1]}}, vsy_reg[VW-1:SP]};
                    mul_b = {{(BW - ppoi_pkg::DT_W){1'b0}}, dt_reg};
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign product  = mul_a * mul_b;
    assign prod_ext = {{(CW - PW){prod_reg[PW-1]}}, prod_reg};

    // position delta, q16.16 rounded half up, then saturating add
    assign rnd_sum  = pacc_reg + POS_HALF;
    assign delta    = rnd_sum[CW-1:ppoi_pkg::ROUND_SHIFT];
    assign pos_base = (cmd.pos_step == ppoi_pkg::PS_YPOS) ? pose_y_reg : pose_x_reg;
    assign pos_sum  = {{(SUM_W - POS_WIDTH){pos_base[POS_WIDTH-1]}}, pos_base}
                    + {{(SUM_W - DW){delta[DW-1]}}, delta};
    assign pos_upd  = sat_pos(pos_sum);

    assign pose_x_ext = {{(SUM_W - POS_WIDTH){pose_x_reg[POS_WIDTH-1]}}, pose_x_reg};
    assign pose_y_ext = {{(SUM_W - POS_WIDTH){pose_y_reg[POS_WIDTH-1]}}, pose_y_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            pose_head_reg <= '0;
        end
        else
        begin
            if (cmd.load_pose)
            begin
                pose_x_reg    <= sat_pos({{(SUM_W - ppoi_pkg::LOAD_W){load_x[ppoi_pkg::LOAD_W-1]}},
                                          load_x});
                pose_y_reg    <= sat_pos({{(SUM_W - ppoi_pkg::LOAD_W){load_y[ppoi_pkg::LOAD_W-1]}},
                                          load_y});
                pose_head_reg <= load_heading;
            end
            if (cmd.head_add)
            begin
                pose_head_reg <= head_new;
            end
            if (cmd.pos && (cmd.pos_step == ppoi_pkg::PS_YHI))
            begin
                pose_x_reg <= pos_upd;
            end
            if (cmd.pos && (cmd.pos_step == ppoi_pkg::PS_YPOS))
            begin
                pose_y_reg <= pos_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= product;
        if (cmd.capture)
        begin
            vx_reg   <= lin_x;
            vy_reg   <= lin_y;
            rate_reg <= ang_rate;
            dt_reg   <= elapsed;
        end
        for (int l = 0; l < 2; l++)
        begin
            if (cmd.head_add)
            begin
                cx_reg[l]   <= ppoi_pkg::CORDIC_X0;
                cy_reg[l]   <= '0;
                cz_reg[l]   <= {2'b00, angle[l][TW-3:0]};
                quad_reg[l] <= angle[l][TW-1:TW-2];
            end
            else if (cmd.rot)
            begin
                cx_reg[l] <= cx_step[l];
                cy_reg[l] <= cy_step[l];
                cz_reg[l] <= cz_step[l];
            end
            if (cmd.map)
            begin
                cos_reg[l] <= c_map[l];
                sin_reg[l] <= s_map[l];
            end
        end
        if (cmd.pos)
        begin
            case (cmd.pos_step)
                ppoi_pkg::PS_VYS:  vsx_reg  <= prod_reg[VW-1:0];
                ppoi_pkg::PS_VXS:  vsx_reg  <= vsx_reg - prod_reg[VW-1:0];
                ppoi_pkg::PS_VYC:  vsy_reg  <= prod_reg[VW-1:0];
                ppoi_pkg::PS_XLO:  vsy_reg  <= vsy_reg + prod_reg[VW-1:0];
                ppoi_pkg::PS_XHI:  pacc_reg <= prod_ext;
                ppoi_pkg::PS_YLO:  pacc_reg <= pacc_reg + (prod_ext <<< SP);
                ppoi_pkg::PS_YHI:  pacc_reg <= prod_ext;
                ppoi_pkg::PS_YACC: pacc_reg <= pacc_reg + (prod_ext <<< SP);
                default:
                begin
                end
            endcase
        end
        if (cmd.out_load)
        begin
            pos_x   <= pose_x_ext[ppoi_pkg::OUT_POS_W-1:0];
            pos_y   <= pose_y_ext[ppoi_pkg::OUT_POS_W-1:0];
            heading <= pose_head_reg;
            quat_z  <= to_q14(sin_reg[1]);
            quat_w  <= to_q14(cos_reg[1]);
        end
    end

endmodule

// ===== sim/planar_pose_odometry_integrator_tb.sv =====
`timescale 1ns / 1ps

module planar_pose_odometry_integrator_tb;

    // block configuration under test
    localparam int POS_WIDTH  = 32;
    localparam int ANGLE_BITS = 16;
    localparam int HEAD_W     = ANGLE_BITS + 1;

    // run shape
    localparam int RANDOM_WORDS = 950;
    localparam int HOLD_WORD    = 300;    // random word index where the long hold-off starts
    localparam int HOLD_CYCLES  = 400;    // receiver hold-off, long enough to back up the input
    localparam int DRAIN_CYCLES = 60;     // stray watch after the last owed result
    localparam int STALL_LIMIT  = 3000;   // cycles with no handshake on either side
    localparam int MAX_PRINTED  = 40;

    // fixed-point constants of the pose math
    localparam longint POS_MAX      = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
    localparam longint POS_MIN      = -(longint'(1) <<< (POS_WIDTH - 1));
    localparam longint CORDIC_START = 652032874;   // 1/K in q1.30
    localparam longint POS_ROUND    = longint'(1) <<< 37;
    localparam longint HEAD_ROUND   = 32768;
    localparam longint QUAT_LIMIT   = 16384;

    // atan(2^-i) as a 32-bit turn fraction
    localparam longint ARCTAN_TURN [0:29] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    typedef struct packed {
        logic                               opcode;
        logic signed [ppoi_pkg::VEL_W-1:0]  lin_x;
        logic signed [ppoi_pkg::VEL_W-1:0]  lin_y;
        logic signed [ppoi_pkg::RATE_W-1:0] ang_rate;
        logic [ppoi_pkg::DT_W-1:0]          elapsed;
        logic signed [ppoi_pkg::LOAD_W-1:0] load_x;
        logic signed [ppoi_pkg::LOAD_W-1:0] load_y;
        logic [HEAD_W-1:0]                  load_heading;
    } sample_word_t;

    typedef struct packed {
        logic signed [ppoi_pkg::OUT_POS_W-1:0] pos_x;
        logic signed [ppoi_pkg::OUT_POS_W-1:0] pos_y;
        logic [HEAD_W-1:0]                     heading;
        logic signed [ppoi_pkg::QUAT_W-1:0]    quat_z;
        logic signed [ppoi_pkg::QUAT_W-1:0]    quat_w;
    } result_word_t;

    // tracks the pose and holds the poses still owed by the block
    class pose_scoreboard;
        longint            pose_x;
        longint            pose_y;
        logic [HEAD_W-1:0] pose_heading;
        result_word_t      expected_poses[$];
        int                errors;

        function new();
            pose_x       = 0;
            pose_y       = 0;
            pose_heading = '0;
            errors       = 0;
        endfunction

        function int pending();
            return expected_poses.size();
        endfunction

        static function longint clamp_pos(longint v);
            if (v > POS_MAX)
                return POS_MAX;
            if (v < POS_MIN)
                return POS_MIN;
            return v;
        endfunction

        // cos and sin in q1.30 of a 32-bit turn fraction
        static function void rotate_turn(input logic [31:0] turn,
                                         output longint cos_v, output longint sin_v);
            longint x, y, z, dx, dy;
            x = CORDIC_START;
            y = 0;
            z = longint'(turn[29:0]);
            for (int i = 0; i < 30; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ARCTAN_TURN[i];
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ARCTAN_TURN[i];
                end
            end
            case (turn[31:30])
                2'd0:
                begin
                    cos_v = x;
                    sin_v = y;
                end
                2'd1:
                begin
                    cos_v = -y;
                    sin_v = x;
                end
                2'd2:
                begin
                    cos_v = -x;
                    sin_v = -y;
                end
                default:
                begin
                    cos_v = y;
                    sin_v = -x;
                end
            endcase
        endfunction

        static function logic [ppoi_pkg::QUAT_W-1:0] to_quat(longint v);
            longint q;
            q = (v + 32768) >>> 16;
            if (q > QUAT_LIMIT)
                q = QUAT_LIMIT;
            if (q < -QUAT_LIMIT)
                q = -QUAT_LIMIT;
            return q[ppoi_pkg::QUAT_W-1:0];
        endfunction

        // one accepted input word: load the pose or integrate one velocity step
        function void note_sample(sample_word_t w);
            longint       c, s, vx, vy, dt, step_x, step_y, dh;
            result_word_t want;
            if (w.opcode == ppoi_pkg::OP_LOAD)
            begin
                pose_x       = clamp_pos(longint'(w.load_x));
                pose_y       = clamp_pos(longint'(w.load_y));
                pose_heading = w.load_heading;
                return;
            end
            vx = longint'(w.lin_x);
            vy = longint'(w.lin_y);
            dt = longint'(w.elapsed);
            // position moves along the old heading, one turn modulo
            rotate_turn({pose_heading[ANGLE_BITS-1:0], {(32 - ANGLE_BITS){1'b0}}}, c, s);
            step_x = (vx * c - vy * s) * dt;
            step_y = (vx * s + vy * c) * dt;
            pose_x = clamp_pos(pose_x + ((step_x + POS_ROUND) >>> 38));
            pose_y = clamp_pos(pose_y + ((step_y + POS_ROUND) >>> 38));
            dh = ($signed(w.ang_rate) * dt + HEAD_ROUND) >>> 16;
            pose_heading = pose_heading + dh[HEAD_W-1:0];
            // quaternion from half the new heading
            rotate_turn({pose_heading, {(31 - ANGLE_BITS){1'b0}}}, c, s);
            want.pos_x   = pose_x[ppoi_pkg::OUT_POS_W-1:0];
            want.pos_y   = pose_y[ppoi_pkg::OUT_POS_W-1:0];
            want.heading = pose_heading;
            want.quat_z  = to_quat(s);
            want.quat_w  = to_quat(c);
            expected_poses.push_back(want);
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(result_word_t got);
            result_word_t want;
            if (expected_poses.size() == 0)
            begin
                report($sformatf("result word with nothing pending, pos_x %h", got.pos_x));
                return;
            end
            want = expected_poses.pop_front();
            if (got.pos_x !== want.pos_x)
                report($sformatf("pos_x got %h want %h", got.pos_x, want.pos_x));
            if (got.pos_y !== want.pos_y)
                report($sformatf("pos_y got %h want %h", got.pos_y, want.pos_y));
            if (got.heading !== want.heading)
                report($sformatf("heading got %h want %h", got.heading, want.heading));
            if (got.quat_z !== want.quat_z)
                report($sformatf("quat_z got %h want %h", got.quat_z, want.quat_z));
            if (got.quat_w !== want.quat_w)
                report($sformatf("quat_w got %h want %h", got.quat_w, want.quat_w));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    // receiver hold-off request and sender no-gap stretch
    logic hold_request = 1'b0;
    int   burst_left   = 0;
    int   stall_cycles = 0;

    pose_scoreboard sb;

    ppoi_in_if  #(.HEAD_W(HEAD_W)) in_ch ();
    ppoi_out_if #(.HEAD_W(HEAD_W)) out_ch ();

    planar_pose_odometry_integrator #(
        .POS_WIDTH  (POS_WIDTH),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (in_ch.sink),
        .result (out_ch.source)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // word builders
    // ---------------------------------------------------------------

    // every field random over its full width
    function automatic sample_word_t noise_word();
        sample_word_t w;
        w.opcode       = 1'($urandom_range(0, 1));
        w.lin_x        = ppoi_pkg::VEL_W'($urandom());
        w.lin_y        = ppoi_pkg::VEL_W'($urandom());
        w.ang_rate     = ppoi_pkg::RATE_W'($urandom());
        w.elapsed      = ppoi_pkg::DT_W'($urandom());
        w.load_x       = $urandom();
        w.load_y       = $urandom();
        w.load_heading = HEAD_W'($urandom());
        return w;
    endfunction

    // velocity word, unused load fields left random
    function automatic sample_word_t velocity_word(int lx, int ly, int rate, int dt);
        sample_word_t w;
        w          = noise_word();
        w.opcode   = ppoi_pkg::OP_INTEGRATE;
        w.lin_x    = ppoi_pkg::VEL_W'(lx);
        w.lin_y    = ppoi_pkg::VEL_W'(ly);
        w.ang_rate = ppoi_pkg::RATE_W'(rate);
        w.elapsed  = ppoi_pkg::DT_W'(dt);
        return w;
    endfunction

    // pose load word, velocity fields left random since the block ignores them
    function automatic sample_word_t pose_load_word(logic [31:0] x, logic [31:0] y, int h);
        sample_word_t w;
        w              = noise_word();
        w.opcode       = ppoi_pkg::OP_LOAD;
        w.load_x       = x;
        w.load_y       = y;
        w.load_heading = HEAD_W'(h);
        return w;
    endfunction

    // random word: mostly velocity steps with a mix of small and full-range values,
    // loads now and then so the pose does not sit at saturation for long
    function automatic sample_word_t random_word();
        sample_word_t w;
        int r;
        w = noise_word();
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            w.opcode = ppoi_pkg::OP_LOAD;
            if ($urandom_range(0, 1) == 0)
            begin
                w.load_x = int'($urandom_range(0, 1 << 25)) - (1 << 24);
                w.load_y = int'($urandom_range(0, 1 << 25)) - (1 << 24);
            end
        end
        else
        begin
            w.opcode = ppoi_pkg::OP_INTEGRATE;
            if ($urandom_range(0, 1) == 0)
            begin
                w.lin_x = ppoi_pkg::VEL_W'(int'($urandom_range(0, 2048)) - 1024);
                w.lin_y = ppoi_pkg::VEL_W'(int'($urandom_range(0, 2048)) - 1024);
            end
            if ($urandom_range(0, 99) >= 35)
                w.ang_rate = ppoi_pkg::RATE_W'(int'($urandom_range(0, 80000)) - 40000);
            r = $urandom_range(0, 99);
            if (r < 10)
                w.elapsed = '0;
            else if (r < 20)
                w.elapsed = '1;
            else if (r >= 55)
                w.elapsed = ppoi_pkg::DT_W'($urandom_range(1, 2000));
        end
        return w;
    endfunction

    // sender gap: mostly back to back, some short, a few long
    function automatic int pick_gap();
        int r;
        if (burst_left > 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------

    // valid stays high across back-to-back words, only dropped for a gap
    task automatic send_word(input sample_word_t w);
        int gap;
        gap = pick_gap();
        if (burst_left > 0)
            burst_left--;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= w.opcode;
        in_ch.lin_x        <= w.lin_x;
        in_ch.lin_y        <= w.lin_y;
        in_ch.ang_rate     <= w.ang_rate;
        in_ch.elapsed      <= w.elapsed;
        in_ch.load_x       <= w.load_x;
        in_ch.load_y       <= w.load_y;
        in_ch.load_heading <= w.load_heading;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_directed();
        // from reset: zero pose, zero motion
        send_word(velocity_word(0, 0, 0, 0));
        // one metre forward over one second
        send_word(velocity_word(256, 0, 0, 65535));
        // rate extremes over the longest step, heading wraps both ways
        send_word(velocity_word(32767, -32768, 1048575, 65535));
        send_word(velocity_word(-32768, 32767, -1048576, 65535));
        // position overflow: x near the top, y near the bottom, both pushed out
        send_word(pose_load_word(32'h7FFF_FF00, 32'h8000_0100, 0));
        send_word(velocity_word(32767, -32768, 0, 65535));
        send_word(velocity_word(-32768, 32767, 0, 65535));
        // load at the field extremes, heading just under two turns
        send_word(pose_load_word(32'h8000_0000, 32'h7FFF_FFFF, (1 << HEAD_W) - 1));
        send_word(velocity_word(-32768, -32768, 0, 65535));
        // heading rolls over from the top of its range to zero
        send_word(velocity_word(32767, 32767, 1, 65535));
        // large velocity with no elapsed time, pose must not move
        send_word(velocity_word(-32768, 32767, 1048575, 0));
        // each quadrant of the old heading and of the half heading
        for (int q = 1; q <= 6; q++)
        begin
            if (q == 5)
                continue;
            send_word(pose_load_word(32'h0001_0000, 32'hFFFF_0000, q << (ANGLE_BITS - 2)));
            send_word(velocity_word(12800, -6400, 0, 6554));
        end
        send_word(pose_load_word(32'h0000_0000, 32'h0000_0000, 1 << ANGLE_BITS));
        send_word(velocity_word(-12800, 6400, 0, 6554));
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial
    begin : stimulus
        sb                 = new();
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.opcode       = ppoi_pkg::OP_INTEGRATE;
        in_ch.lin_x        = '0;
        in_ch.lin_y        = '0;
        in_ch.ang_rate     = '0;
        in_ch.elapsed      = '0;
        in_ch.load_x       = '0;
        in_ch.load_y       = '0;
        in_ch.load_heading = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();

        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            if (k == HOLD_WORD)
            begin
                // receiver stops for a long while, sender keeps pushing until it stalls
                hold_request = 1'b1;
                burst_left   = 40;
            end
            else if (k % 150 == 75)
            begin
                burst_left = 30;
            end
            send_word(random_word());
        end
        in_ch.valid <= 1'b0;

        // let everything owed come out, then watch for strays
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // receiver: random ready with bursts, stalls and one long hold-off
    // ---------------------------------------------------------------

    initial
    begin : receiver
        int pick;
        int len;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    out_ch.ready <= 1'b1;
                    len = $urandom_range(1, 24);
                end
                else if (pick < 93)
                begin
                    out_ch.ready <= 1'b0;
                    len = $urandom_range(1, 4);
                end
                else
                begin
                    out_ch.ready <= 1'b0;
                    len = $urandom_range(12, 50);
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // monitors: sampled at the edge, before any update of that edge lands
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : input_monitor
        sample_word_t w;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            w.opcode       = in_ch.opcode;
            w.lin_x        = in_ch.lin_x;
            w.lin_y        = in_ch.lin_y;
            w.ang_rate     = in_ch.ang_rate;
            w.elapsed      = in_ch.elapsed;
            w.load_x       = in_ch.load_x;
            w.load_y       = in_ch.load_y;
            w.load_heading = in_ch.load_heading;
            sb.note_sample(w);
        end
    end

    always @(posedge clk)
    begin : output_monitor
        result_word_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got.pos_x   = out_ch.pos_x;
            got.pos_y   = out_ch.pos_y;
            got.heading = out_ch.heading;
            got.quat_z  = out_ch.quat_z;
            got.quat_w  = out_ch.quat_w;
            sb.check_result(got);
        end
    end

    // watchdog: no handshake on either side for too long ends the run
    always @(posedge clk)
    begin : watchdog
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
rtl/ppoi_pkg.sv
rtl/ppoi_in_if.sv
rtl/ppoi_out_if.sv
rtl/ppoi_ctrl.sv
rtl/ppoi_dp.sv
rtl/planar_pose_odometry_integrator.sv
sim/planar_pose_odometry_integrator_tb.sv
